@@ design/glyph_coverage_pixel_blend_unit_defines.svh @@
// assertion macros shared by the glyph blend checker
// no dependencies; include guard keeps it single
`ifndef GLYPH_COVERAGE_PIXEL_BLEND_UNIT_DEFINES_SVH
`define GLYPH_COVERAGE_PIXEL_BLEND_UNIT_DEFINES_SVH

// same-cycle implication, masked while reset is asserted
`define GCPB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is asserted
`define GCPB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// check on the cycle after each cycle in which reset is asserted
`define GCPB_ASSERT_RST(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) (!(rst_n)) |=> (cons)) \
        else $error(msg);

`endif

@@ design/gcpb_pkg.sv @@
// shared types and constants of the glyph coverage pixel blend unit
// no dependencies; compiled before all other design files
`timescale 1ns / 1ps
`default_nettype none

package gcpb_pkg;

    // glyph bitmap bound; columns and rows at or above it are clipped
    localparam int GLYPH_DIM = 256;
    localparam int GDIM_W    = 11;

    // field widths
    localparam int COV_W    = 8;
    localparam int POS_W    = 8;
    localparam int ORG_W    = 12;
    localparam int PIX_W    = 32;
    localparam int ADDR_W   = 20;
    localparam int REG_W    = 11;
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_WIDTH  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_HEIGHT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE = 8'd3;

    // register reset values
    localparam logic [PIX_W-1:0] RST_TEXT_COLOR  = 32'hFFFF_FFFF;
    localparam logic [REG_W-1:0] RST_CLIP_WIDTH  = 11'd480;
    localparam logic [REG_W-1:0] RST_CLIP_HEIGHT = 11'd272;
    localparam logic [REG_W-1:0] RST_LINE_STRIDE = 11'd512;

    // configuration seen by the datapath
    typedef struct packed {
        logic [PIX_W-1:0] text_color;
        logic [REG_W-1:0] clip_width;
        logic [REG_W-1:0] clip_height;
        logic [REG_W-1:0] line_stride;
    } t_cfg;

    // one registered input pixel
    typedef struct packed {
        logic [COV_W-1:0]        coverage;
        logic [POS_W-1:0]        glyph_col;
        logic [POS_W-1:0]        glyph_row;
        logic signed [ORG_W-1:0] origin_x;
        logic signed [ORG_W-1:0] origin_y;
        logic [PIX_W-1:0]        dest_pixel;
    } t_pix_item;

    // one registered result
    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] pixel_address;
        logic [PIX_W-1:0]  new_pixel;
    } t_res_item;

endpackage

`default_nettype wire

@@ design/gcpb_if.sv @@
// pixel input and result output channel interfaces
// depends on gcpb_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface gcpb_pix_if import gcpb_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [COV_W-1:0]        coverage;
    logic [POS_W-1:0]        glyph_col;
    logic [POS_W-1:0]        glyph_row;
    logic signed [ORG_W-1:0] origin_x;
    logic signed [ORG_W-1:0] origin_y;
    logic [PIX_W-1:0]        dest_pixel;

    modport source (
        output valid, coverage, glyph_col, glyph_row, origin_x, origin_y, dest_pixel,
        input  ready
    );
    modport sink (
        input  valid, coverage, glyph_col, glyph_row, origin_x, origin_y, dest_pixel,
        output ready
    );
endinterface

interface gcpb_res_if import gcpb_pkg::*;;
    logic              valid;
    logic              ready;
    logic              write_enable;
    logic [ADDR_W-1:0] pixel_address;
    logic [PIX_W-1:0]  new_pixel;

    modport source (
        output valid, write_enable, pixel_address, new_pixel,
        input  ready
    );
    modport sink (
        input  valid, write_enable, pixel_address, new_pixel,
        output ready
    );
endinterface

`default_nettype wire

@@ design/gcpb_cfg_regs.sv @@
// configuration register file: text color, clip size and line stride
// depends on gcpb_pkg
`timescale 1ns / 1ps
`default_nettype none

module gcpb_cfg_regs import gcpb_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // writes are always taken
    assign o_cfg_ready = 1'b1;

    // decode the register index, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TEXT_COLOR:  n_cfg.text_color  = i_cfg_data[PIX_W-1:0];
                REG_CLIP_WIDTH:  n_cfg.clip_width  = i_cfg_data[REG_W-1:0];
                REG_CLIP_HEIGHT: n_cfg.clip_height = i_cfg_data[REG_W-1:0];
                REG_LINE_STRIDE: n_cfg.line_stride = i_cfg_data[REG_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.text_color  <= RST_TEXT_COLOR;
            r_cfg.clip_width  <= RST_CLIP_WIDTH;
            r_cfg.clip_height <= RST_CLIP_HEIGHT;
            r_cfg.line_stride <= RST_LINE_STRIDE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ design/gcpb_blend_core.sv @@
// two-register blend datapath: input register, clip/blend/address logic,
// result register; depends on gcpb_pkg and gcpb_if
`timescale 1ns / 1ps
`default_nettype none

module gcpb_blend_core import gcpb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    gcpb_pix_if.sink   i_pix,
    gcpb_res_if.source o_res
);

    logic      r_s1_valid;
    t_pix_item r_s1;
    logic      r_s2_valid;
    t_res_item r_s2;
    t_res_item n_s2;
    logic      w_s2_free;
    logic      w_s1_free;

    // floor(p / 255) for p up to 255*255 by reciprocal with correction
    function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] p);
        logic [2*CH_W-1:0] s;
        s = p + {{(2*CH_W-1){1'b0}}, 1'b1} + {{CH_W{1'b0}}, p[2*CH_W-1:CH_W]};
        return s[2*CH_W-1:CH_W];
    endfunction

    // flow control: each register frees when its contents move on
    assign w_s2_free   = !r_s2_valid || o_res.ready;
    assign w_s1_free   = !r_s1_valid || w_s2_free;
    assign i_pix.ready = w_s1_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_free && i_pix.valid) begin
            r_s1.coverage   <= i_pix.coverage;
            r_s1.glyph_col  <= i_pix.glyph_col;
            r_s1.glyph_row  <= i_pix.glyph_row;
            r_s1.origin_x   <= i_pix.origin_x;
            r_s1.origin_y   <= i_pix.origin_y;
            r_s1.dest_pixel <= i_pix.dest_pixel;
        end
    end

    // clip test, per-channel blend and word address
    always_comb begin
        logic [ORG_W:0]      v_x;
        logic [ORG_W:0]      v_y;
        logic                v_inside;
        logic [CH_W-1:0]     v_inv;
        logic [CH_W-1:0]     v_fg;
        logic [CH_W-1:0]     v_bg;
        logic [PIX_W-1:0]    v_pix;
        logic [2*REG_W-1:0]  v_addr;

        v_x = {r_s1.origin_x[ORG_W-1], r_s1.origin_x}
            + {{(ORG_W+1-POS_W){1'b0}}, r_s1.glyph_col};
        v_y = {r_s1.origin_y[ORG_W-1], r_s1.origin_y}
            + {{(ORG_W+1-POS_W){1'b0}}, r_s1.glyph_row};

        v_inside = (GDIM_W'(r_s1.glyph_col) < GDIM_W'(GLYPH_DIM))
                && (GDIM_W'(r_s1.glyph_row) < GDIM_W'(GLYPH_DIM))
                && !v_x[ORG_W] && !v_y[ORG_W]
                && (v_x[ORG_W-1:0] < {1'b0, i_cfg.clip_width})
                && (v_y[ORG_W-1:0] < {1'b0, i_cfg.clip_height});

        // four independent channel lanes
        v_inv = CH_MAX - r_s1.coverage;
        v_pix = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            v_fg = i_cfg.text_color[i*CH_W +: CH_W];
            v_bg = r_s1.dest_pixel[i*CH_W +: CH_W];
            v_pix[i*CH_W +: CH_W] = div255(16'(v_fg) * 16'(r_s1.coverage))
                                  + div255(16'(v_inv) * 16'(v_bg));
        end

        // inside the clip region both coordinates fit the register width
        v_addr = (22'(v_y[REG_W-1:0]) * 22'(i_cfg.line_stride))
               + 22'(v_x[REG_W-1:0]);

        n_s2.write_enable = v_inside;
        if (v_inside) begin
            n_s2.pixel_address = v_addr[ADDR_W-1:0];
            n_s2.new_pixel     = v_pix;
        end else begin
            n_s2.pixel_address = '0;
            n_s2.new_pixel     = r_s1.dest_pixel;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_free && r_s1_valid) begin
            r_s2 <= n_s2;
        end
    end

    assign o_res.valid         = r_s2_valid;
    assign o_res.write_enable  = r_s2.write_enable;
    assign o_res.pixel_address = r_s2.pixel_address;
    assign o_res.new_pixel     = r_s2.new_pixel;

endmodule

`default_nettype wire

@@ design/glyph_coverage_pixel_blend_unit.sv @@
// Glyph coverage pixel blend unit. Takes one glyph pixel per clock while the result side
// keeps taking and returns one result per pixel: each pixel passes the input register, then
// the clip test, the four 8x8 channel multiply/divide-by-255 lanes and the 11x11 address
// multiply into the result register. Sustained rate is one pixel per cycle while the result
// side keeps taking. Configuration writes are registered and must be made while no pixel
// is in flight. No memories, so no clearing pass after reset.
// top level; depends on gcpb_pkg, gcpb_if, gcpb_cfg_regs and gcpb_blend_core
`timescale 1ns / 1ps
`default_nettype none

module glyph_coverage_pixel_blend_unit import gcpb_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    gcpb_pix_if.sink                   i_pix,
    gcpb_res_if.source                 o_res
);

    t_cfg w_cfg;

    // register file
    gcpb_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // blend datapath
    gcpb_blend_core u_blend_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_pix   (i_pix),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

@@ design/gcpb_checker.sv @@
// port-level checks of the glyph blend unit, bound to the top level
// depends on gcpb_pkg and glyph_coverage_pixel_blend_unit_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "glyph_coverage_pixel_blend_unit_defines.svh"

module gcpb_checker import gcpb_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic              i_out_we,
    input wire logic [ADDR_W-1:0] i_out_addr
);

    logic w_in_xfer;
    assign w_in_xfer = i_in_valid && i_in_ready;

    // a stalled result stays offered
    `GCPB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    // clipped pixels carry a zero address
    `GCPB_ASSERT_IMP(a_clip_addr, i_clk, i_rst_n, i_out_valid && !i_out_we, i_out_addr == '0, "nonzero address on clipped pixel")

    // a result appearing on an empty output comes from an input transfer through both registers
    `GCPB_ASSERT_IMP(a_latency, i_clk, i_rst_n, $rose(i_out_valid), $past(w_in_xfer, 2), "result without matching input transfer")

    // reset empties the pipeline
    `GCPB_ASSERT_RST(a_rst_empty, i_clk, i_rst_n, !i_out_valid, "result offered after reset")

endmodule

bind glyph_coverage_pixel_blend_unit gcpb_checker u_gcpb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_we    (o_res.write_enable),
    .i_out_addr  (o_res.pixel_address)
);

`default_nettype wire
